/* src/assert_macros.svh */
// Assertion macros shared by the editor RTL.
// Self-contained; taken in by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* src/mrce_pkg.sv */
// Shared types and fixed field widths for the matrix row/column editor.
// No dependencies; imported by mrce_cell_store, matrix_row_column_editor and the testbench.
package mrce_pkg;

  localparam int OP_W       = 4;
  localparam int INDEX_W    = 7;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int EXT_W      = 64;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 4'd0,
    OP_READ     = 4'd1,
    OP_SWAP_ROW = 4'd2,
    OP_SWAP_COL = 4'd3,
    OP_DEL_ROW  = 4'd4,
    OP_DEL_COL  = 4'd5,
    OP_INS_ROW  = 4'd6,
    OP_INS_COL  = 4'd7,
    OP_RESTART  = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_ROWS = 1'b0,
    CFG_INIT_COLS = 1'b1
  } cfg_idx_t;

  // Commands from the sequencer to the cell store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic mark_all;
    logic mark_one;
    logic unmark_one;
  } cell_ctl_t;

endpackage

/* src/mrce_cell_store.sv */
// Cell store: physical cell memory addressed by physical row and column,
// with one stale mark per physical row so a stale row reads as zero.
// Depends on mrce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrce_cell_store #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int CELL_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mrce_pkg::cell_ctl_t                 ctl,
  input  logic [$clog2(MAX_ROWS)-1:0]         row,
  input  logic [$clog2(MAX_COLS)-1:0]         col,
  input  logic [CELL_WIDTH-1:0]               wdata,
  output logic [CELL_WIDTH-1:0]               rdata,
  output logic                                row_stale
);
  import mrce_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  logic [CELL_WIDTH-1:0] cell_mem [DEPTH];
  logic [CELL_WIDTH-1:0] rd_q_r;
  logic                  rd_stale_r;
  logic [MAX_ROWS-1:0]   stale_r;
  logic [AW-1:0]         addr;

  // Flatten physical row and column into a memory address
  assign addr = AW'(row) * AW'(MAX_COLS) + AW'(col);

  // Write and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      cell_mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_q_r     <= cell_mem[addr];
      rd_stale_r <= stale_r[row];
    end
  end

  // Stale marks: reset and a whole-table restart mark every row; single rows are marked or cleared by row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= '1;
    end else if (ctl.mark_all) begin
      stale_r <= '1;
    end else if (ctl.mark_one) begin
      stale_r[row] <= 1'b1;
    end else if (ctl.unmark_one) begin
      stale_r[row] <= 1'b0;
    end
  end

  assign rdata     = rd_stale_r ? '0 : rd_q_r;
  assign row_stale = stale_r[row];

  `ASSERT_ALWAYS(a_rd_wr_excl, clk, rst_n, !(ctl.rd_en && ctl.wr_en), "cell read and write together")
  `ASSERT_NEXT(a_mark_all, clk, rst_n, ctl.mark_all, &stale_r, "restart left a row unmarked")
  `ASSERT_NEXT(a_unmark, clk, rst_n, ctl.unmark_one && !ctl.mark_all && !ctl.mark_one, !stale_r[$past(row)], "row still stale after clear")

endmodule

/* src/matrix_row_column_editor.sv */
// Matrix row/column editor: a table of signed cells (up to MAX_ROWS x MAX_COLS)
// edited through logical-to-physical row and column maps held in one map memory,
// with physical cells in mrce_cell_store. A small sequencer walks the map memory
// one port access per cycle. Errors and restart go straight to the result; swap
// reads both map entries and writes them back crossed; read and load look up
// the physical row and column, then the cell, and a load first zeroes the whole
// row when it is still marked stale (first load into a row after restart or row
// insert); delete or insert saves a map entry, shifts the live ones past it
// one place through the single map read port, drops the saved entry into the
// freed slot; a column insert then zeroes its physical column. After reset the
// maps are set to identity before any item; config writes are always taken.
// Depends on mrce_pkg, mrce_cell_store and assert_macros.svh.
`include "assert_macros.svh"

module matrix_row_column_editor #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int CELL_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // config write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mrce_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mrce_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [mrce_pkg::OP_W-1:0]              in_operation,
  input  logic [mrce_pkg::INDEX_W-1:0]           in_first_index,
  input  logic [mrce_pkg::INDEX_W-1:0]           in_second_index,
  input  logic signed [mrce_pkg::VALUE_W-1:0]    in_cell_value,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mrce_pkg::VALUE_W-1:0]    out_read_value,
  output logic [mrce_pkg::STATUS_W-1:0]          out_status,
  output logic [mrce_pkg::INDEX_W-1:0]           out_rows_now,
  output logic [mrce_pkg::INDEX_W-1:0]           out_cols_now
);
  import mrce_pkg::*;

  localparam int RW        = $clog2(MAX_ROWS);
  localparam int CW        = $clog2(MAX_COLS);
  localparam int PW        = (RW > CW) ? RW : CW;
  localparam int MAP_DEPTH = MAX_ROWS + MAX_COLS;
  localparam int MW        = $clog2(MAP_DEPTH);
  localparam int RCW       = $clog2(MAX_ROWS + 1);
  localparam int CCW       = $clog2(MAX_COLS + 1);
  localparam int CNT_MAXW  = (RCW > CCW) ? RCW : CCW;
  localparam int EXTW      = ((CNT_MAXW > INDEX_W) ? CNT_MAXW : INDEX_W) + 1;

  localparam logic [MW-1:0]   COL_BASE   = MW'(MAX_ROWS);
  localparam logic [MW-1:0]   LAST_MAP   = MW'(MAP_DEPTH - 1);
  localparam logic [MW-1:0]   ROW_LAST   = MW'(MAX_ROWS - 1);
  localparam logic [MW-1:0]   COL_LAST   = MW'(MAX_COLS - 1);
  localparam logic [EXTW-1:0] ROWS_MAX_E = EXTW'(MAX_ROWS);
  localparam logic [EXTW-1:0] COLS_MAX_E = EXTW'(MAX_COLS);

  typedef enum logic [15:0] {
    S_INIT   = 16'h0001,
    S_IDLE   = 16'h0002,
    S_RD1    = 16'h0004,
    S_RD2    = 16'h0008,
    S_RD3    = 16'h0010,
    S_SWAP2  = 16'h0020,
    S_CELL   = 16'h0040,
    S_RDCAP  = 16'h0080,
    S_ROWCLR = 16'h0100,
    S_SAVE   = 16'h0200,
    S_SAVE2  = 16'h0400,
    S_SHR    = 16'h0800,
    S_SHW    = 16'h1000,
    S_FINW   = 16'h2000,
    S_COLCLR = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [MW-1:0]         k_r, k_nxt;
  logic [MW-1:0]         f_r, f_nxt;
  logic [PW-1:0]         tmp_r, tmp_nxt;
  logic [CW-1:0]         pc_r, pc_nxt;
  logic                  dir_up_r, dir_up_nxt;
  logic [CELL_WIDTH-1:0] val_r, val_nxt;
  logic [RCW-1:0]        row_cnt_r, row_cnt_nxt;
  logic [CCW-1:0]        col_cnt_r, col_cnt_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]    res_value_r, res_value_nxt;
  logic [CFG_DATA_W-1:0] init_rows_r, init_cols_r;

  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_read_value_r;
  status_t               out_status_r;
  logic [INDEX_W-1:0]    out_rows_now_r, out_cols_now_r;

  // map memory port
  logic [PW-1:0]         map_mem [MAP_DEPTH];
  logic [PW-1:0]         map_q_r;
  logic [MW-1:0]         map_raddr;
  logic                  map_we;
  logic [MW-1:0]         map_waddr;
  logic [PW-1:0]         map_wdata;

  // cell store port
  cell_ctl_t             cell_ctl;
  logic [RW-1:0]         cell_row;
  logic [CW-1:0]         cell_col;
  logic [CELL_WIDTH-1:0] cell_wdata;
  logic [CELL_WIDTH-1:0] cell_rdata;
  logic                  cell_row_stale;

  // decode helpers
  logic [EXTW-1:0]       i1_e, i2_e, rc_e, cc_e, i1m, i2m, ir_e, ic_e;
  logic                  row1_ok, row2_ok, col1_ok, col2_ok;
  logic                  row_ins_ok, col_ins_ok, rows_full, cols_full;
  logic [MW-1:0]         a_row1, a_row2, a_col1, a_col2;
  logic [MW-1:0]         row_last, row_end, col_last, col_end;
  logic [MW-1:0]         k_step;
  logic [RCW-1:0]        sat_rows;
  logic [CCW-1:0]        sat_cols;
  logic signed [EXT_W-1:0] ld_ext, rd_ext;
  logic                  out_free;

  mrce_cell_store #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_cell_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cell_ctl),
    .row       (cell_row),
    .col       (cell_col),
    .wdata     (cell_wdata),
    .rdata     (cell_rdata),
    .row_stale (cell_row_stale)
  );

  // Map memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q_r <= map_mem[map_raddr];
  end

  // Range checks and map addresses for the incoming beat
  assign i1_e = EXTW'(in_first_index);
  assign i2_e = EXTW'(in_second_index);
  assign rc_e = EXTW'(row_cnt_r);
  assign cc_e = EXTW'(col_cnt_r);
  assign i1m  = i1_e - EXTW'(1);
  assign i2m  = i2_e - EXTW'(1);

  assign row1_ok    = (i1_e != '0) && (i1_e <= rc_e);
  assign row2_ok    = (i2_e != '0) && (i2_e <= rc_e);
  assign col1_ok    = (i1_e != '0) && (i1_e <= cc_e);
  assign col2_ok    = (i2_e != '0) && (i2_e <= cc_e);
  assign row_ins_ok = (i1_e != '0) && (i1_e <= rc_e + EXTW'(1));
  assign col_ins_ok = (i1_e != '0) && (i1_e <= cc_e + EXTW'(1));
  assign rows_full  = rc_e >= ROWS_MAX_E;
  assign cols_full  = cc_e >= COLS_MAX_E;

  assign a_row1   = MW'(i1m);
  assign a_row2   = MW'(i2m);
  assign a_col1   = COL_BASE + MW'(i1m);
  assign a_col2   = COL_BASE + MW'(i2m);
  assign row_last = MW'(rc_e - EXTW'(1));
  assign row_end  = MW'(rc_e);
  assign col_last = COL_BASE + MW'(cc_e - EXTW'(1));
  assign col_end  = COL_BASE + MW'(cc_e);

  assign k_step = dir_up_r ? (k_r + MW'(1)) : (k_r - MW'(1));

  // Restart counts saturate at the table size
  assign ir_e     = EXTW'(init_rows_r);
  assign ic_e     = EXTW'(init_cols_r);
  assign sat_rows = (ir_e > ROWS_MAX_E) ? RCW'(MAX_ROWS) : RCW'(init_rows_r);
  assign sat_cols = (ic_e > COLS_MAX_E) ? CCW'(MAX_COLS) : CCW'(init_cols_r);

  // Cell width conversion on load and read
  assign ld_ext = EXT_W'(in_cell_value);
  assign rd_ext = EXT_W'(signed'(cell_rdata));

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    k_nxt          = k_r;
    f_nxt          = f_r;
    tmp_nxt        = tmp_r;
    pc_nxt         = pc_r;
    dir_up_nxt     = dir_up_r;
    val_nxt        = val_r;
    row_cnt_nxt    = row_cnt_r;
    col_cnt_nxt    = col_cnt_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;

    map_raddr  = k_r;
    map_we     = 1'b0;
    map_waddr  = k_r;
    map_wdata  = map_q_r;

    cell_ctl   = '0;
    cell_row   = tmp_r[RW-1:0];
    cell_col   = pc_r;
    cell_wdata = '0;

    unique case (state_r)
      S_INIT: begin
        // write the identity permutation into both maps
        map_we    = 1'b1;
        map_wdata = (k_r < COL_BASE) ? PW'(k_r) : PW'(k_r - COL_BASE);
        if (k_r == LAST_MAP) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + MW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = op_t'(in_operation);
          val_nxt        = ld_ext[CELL_WIDTH-1:0];
          res_value_nxt  = '0;
          res_status_nxt = ST_DONE;
          state_nxt      = S_DONE;
          unique case (in_operation)
            OP_LOAD, OP_READ: begin
              if (row1_ok && col2_ok) begin
                k_nxt     = a_row1;
                f_nxt     = a_col2;
                state_nxt = S_RD1;
              end else begin
                res_status_nxt = ST_RANGE;
              end
            end
            OP_SWAP_ROW: begin
              if (row1_ok && row2_ok) begin
                k_nxt     = a_row1;
                f_nxt     = a_row2;
                state_nxt = S_RD1;
              end else begin
                res_status_nxt = ST_RANGE;
              end
            end
            OP_SWAP_COL: begin
              if (col1_ok && col2_ok) begin
                k_nxt     = a_col1;
                f_nxt     = a_col2;
                state_nxt = S_RD1;
              end else begin
                res_status_nxt = ST_RANGE;
              end
            end
            OP_DEL_ROW: begin
              if (row1_ok) begin
                k_nxt      = a_row1;
                f_nxt      = row_last;
                dir_up_nxt = 1'b1;
                state_nxt  = S_SAVE;
              end else begin
                res_status_nxt = ST_RANGE;
              end
            end
            OP_DEL_COL: begin
              if (col1_ok) begin
                k_nxt      = a_col1;
                f_nxt      = col_last;
                dir_up_nxt = 1'b1;
                state_nxt  = S_SAVE;
              end else begin
                res_status_nxt = ST_RANGE;
              end
            end
            OP_INS_ROW: begin
              if (!row_ins_ok) begin
                res_status_nxt = ST_RANGE;
              end else if (rows_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                k_nxt      = row_end;
                f_nxt      = a_row1;
                dir_up_nxt = 1'b0;
                state_nxt  = S_SAVE;
              end
            end
            OP_INS_COL: begin
              if (!col_ins_ok) begin
                res_status_nxt = ST_RANGE;
              end else if (cols_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                k_nxt      = col_end;
                f_nxt      = a_col1;
                dir_up_nxt = 1'b0;
                state_nxt  = S_SAVE;
              end
            end
            OP_RESTART: begin
              row_cnt_nxt       = sat_rows;
              col_cnt_nxt       = sat_cols;
              cell_ctl.mark_all = 1'b1;
            end
            default: begin
              res_status_nxt = ST_RANGE;
            end
          endcase
        end
      end

      S_RD1: begin
        map_raddr = k_r;
        state_nxt = S_RD2;
      end

      S_RD2: begin
        map_raddr = f_r;
        tmp_nxt   = map_q_r;
        state_nxt = S_RD3;
      end

      S_RD3: begin
        if ((op_r == OP_SWAP_ROW) || (op_r == OP_SWAP_COL)) begin
          map_we    = 1'b1;
          map_waddr = k_r;
          map_wdata = map_q_r;
          state_nxt = S_SWAP2;
        end else begin
          pc_nxt    = map_q_r[CW-1:0];
          state_nxt = S_CELL;
        end
      end

      S_SWAP2: begin
        map_we    = 1'b1;
        map_waddr = f_r;
        map_wdata = tmp_r;
        state_nxt = S_DONE;
      end

      S_CELL: begin
        cell_row = tmp_r[RW-1:0];
        cell_col = pc_r;
        if (op_r == OP_READ) begin
          cell_ctl.rd_en = 1'b1;
          state_nxt      = S_RDCAP;
        end else if (cell_row_stale) begin
          // zero the whole row before the first load lands in it
          k_nxt     = '0;
          state_nxt = S_ROWCLR;
        end else begin
          cell_ctl.wr_en = 1'b1;
          cell_wdata     = val_r;
          state_nxt      = S_DONE;
        end
      end

      S_RDCAP: begin
        res_value_nxt = rd_ext[VALUE_W-1:0];
        state_nxt     = S_DONE;
      end

      S_ROWCLR: begin
        cell_row       = tmp_r[RW-1:0];
        cell_col       = k_r[CW-1:0];
        cell_ctl.wr_en = 1'b1;
        cell_wdata     = '0;
        if (k_r == COL_LAST) begin
          cell_ctl.unmark_one = 1'b1;
          state_nxt           = S_CELL;
        end else begin
          k_nxt = k_r + MW'(1);
        end
      end

      S_SAVE: begin
        map_raddr = k_r;
        state_nxt = S_SAVE2;
      end

      S_SAVE2: begin
        tmp_nxt   = map_q_r;
        state_nxt = (k_r == f_r) ? S_FINW : S_SHR;
      end

      S_SHR: begin
        map_raddr = k_step;
        state_nxt = S_SHW;
      end

      S_SHW: begin
        map_we    = 1'b1;
        map_waddr = k_r;
        map_wdata = map_q_r;
        k_nxt     = k_step;
        state_nxt = (k_step == f_r) ? S_FINW : S_SHR;
      end

      S_FINW: begin
        // drop the saved physical line into its final slot
        map_we    = 1'b1;
        map_waddr = f_r;
        map_wdata = tmp_r;
        state_nxt = S_DONE;
        unique case (op_r)
          OP_DEL_ROW: row_cnt_nxt = row_cnt_r - RCW'(1);
          OP_DEL_COL: col_cnt_nxt = col_cnt_r - CCW'(1);
          OP_INS_ROW: begin
            row_cnt_nxt       = row_cnt_r + RCW'(1);
            cell_row          = tmp_r[RW-1:0];
            cell_ctl.mark_one = 1'b1;
          end
          OP_INS_COL: begin
            col_cnt_nxt = col_cnt_r + CCW'(1);
            k_nxt       = '0;
            state_nxt   = S_COLCLR;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_COLCLR: begin
        cell_row       = k_r[RW-1:0];
        cell_col       = tmp_r[CW-1:0];
        cell_ctl.wr_en = 1'b1;
        cell_wdata     = '0;
        if (k_r == ROW_LAST) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + MW'(1);
        end
      end

      S_DONE: begin
        // hold until the output register can take the beat
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      k_r       <= '0;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    f_r          <= f_nxt;
    tmp_r        <= tmp_nxt;
    pc_r         <= pc_nxt;
    dir_up_r     <= dir_up_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
  end

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_rows_r <= '0;
      init_cols_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INIT_ROWS: init_rows_r <= cfg_data;
        CFG_INIT_COLS: init_cols_r <= cfg_data;
      endcase
    end
  end

  // Output register: load a beat when free, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_read_value_r <= res_value_r;
      out_status_r     <= res_status_r;
      out_rows_now_r   <= rc_e[INDEX_W-1:0];
      out_cols_now_r   <= cc_e[INDEX_W-1:0];
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_rows_now   = out_rows_now_r;
  assign out_cols_now   = out_cols_now_r;

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE, "accepted beat did not start work")
  `ASSERT_ALWAYS(a_counts_bound, clk, rst_n, (row_cnt_r <= RCW'(MAX_ROWS)) && (col_cnt_r <= CCW'(MAX_COLS)), "live count above table size")
  `ASSERT_NEXT(a_result_waits, clk, rst_n, (state_r == S_DONE) && out_valid_r && out_stall, state_r == S_DONE, "result left while output blocked")

endmodule

/* tb/matrix_row_column_editor_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for matrix_row_column_editor: a scripted opening, then
// random edit phases under several start sizes, checked against a local table.
// Depends on mrce_pkg and the editor RTL.
module matrix_row_column_editor_tb;
  import mrce_pkg::*;

  localparam int ROWS_MAX    = 64;
  localparam int COLS_MAX    = 64;
  localparam int INDEX_LIMIT = 64;
  localparam int PHASES      = 6;
  localparam int PHASE_EDITS = 240;
  localparam int QUIET_PHASE = 2;
  localparam int TAIL_CYCLES = 200;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd9;
  localparam logic [OP_W-1:0] OP_UNUSED       = 4'd15;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_t                   status;
    logic [INDEX_W-1:0]        rows_now;
    logic [INDEX_W-1:0]        cols_now;
  } reply_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] first;
    logic [INDEX_W-1:0] second;
    logic [VALUE_W-1:0] value;
    logic               typed;
    reply_t             want;
  } edit_t;

  localparam reply_t NO_REPLY = '0;
  localparam edit_t RESTART_EDIT = '{OP_RESTART, 7'd0, 7'd0, 32'h0, 1'b0, NO_REPLY};

  // Start sizes per random phase: empty, full, thin, saturating, small, narrow
  localparam logic [CFG_DATA_W-1:0] PHASE_ROWS [PHASES] = '{7'd0, 7'd64, 7'd1, 7'd100,
                                                            7'd6, 7'd3};
  localparam logic [CFG_DATA_W-1:0] PHASE_COLS [PHASES] = '{7'd0, 7'd64, 7'd64, 7'd3,
                                                            7'd6, 7'd12};

  // Opening edits; expected replies typed in where they are obvious
  localparam edit_t SCRIPT [26] = '{
    '{OP_READ,     7'd1,  7'd1,  32'h0,        1'b1, '{32'sh0, ST_RANGE, 7'd0, 7'd0}},
    '{OP_UNUSED,   7'd3,  7'd3,  32'h0,        1'b1, '{32'sh0, ST_RANGE, 7'd0, 7'd0}},
    '{OP_INS_ROW,  7'd2,  7'd0,  32'h0,        1'b1, '{32'sh0, ST_RANGE, 7'd0, 7'd0}},
    '{OP_INS_ROW,  7'd1,  7'd0,  32'h0,        1'b1, '{32'sh0, ST_DONE,  7'd1, 7'd0}},
    '{OP_INS_COL,  7'd1,  7'd0,  32'h0,        1'b1, '{32'sh0, ST_DONE,  7'd1, 7'd1}},
    '{OP_READ,     7'd1,  7'd1,  32'h0,        1'b1, '{32'sh0, ST_DONE,  7'd1, 7'd1}},
    '{OP_LOAD,     7'd1,  7'd1,  32'h7FFFFFFF, 1'b1, '{32'sh0, ST_DONE,  7'd1, 7'd1}},
    '{OP_READ,     7'd1,  7'd1,  32'h0,        1'b1,
      '{32'sh7FFFFFFF, ST_DONE, 7'd1, 7'd1}},
    '{OP_RESTART,  7'd5,  7'd9,  32'h12345678, 1'b1, '{32'sh0, ST_DONE, 7'd64, 7'd64}},
    '{OP_READ,     7'd1,  7'd1,  32'h0,        1'b1, '{32'sh0, ST_DONE, 7'd64, 7'd64}},
    '{OP_LOAD,     7'd64, 7'd64, 32'h80000000, 1'b1, '{32'sh0, ST_DONE, 7'd64, 7'd64}},
    '{OP_READ,     7'd64, 7'd64, 32'h0,        1'b1,
      '{32'sh80000000, ST_DONE, 7'd64, 7'd64}},
    '{OP_LOAD,     7'd1,  7'd64, 32'hFFFFFFFF, 1'b1, '{32'sh0, ST_DONE, 7'd64, 7'd64}},
    '{OP_LOAD,     7'd0,  7'd5,  32'h5A5A5A5A, 1'b1, '{32'sh0, ST_RANGE, 7'd64, 7'd64}},
    '{OP_READ,     7'd5,  7'd0,  32'h0,        1'b1, '{32'sh0, ST_RANGE, 7'd64, 7'd64}},
    '{OP_INS_ROW,  7'd1,  7'd0,  32'h0,        1'b1, '{32'sh0, ST_FULL,  7'd64, 7'd64}},
    '{OP_INS_COL,  7'd64, 7'd0,  32'h0,        1'b1, '{32'sh0, ST_FULL,  7'd64, 7'd64}},
    '{OP_SWAP_ROW, 7'd1,  7'd64, 32'h0,        1'b0, NO_REPLY},
    '{OP_SWAP_COL, 7'd64, 7'd1,  32'h0,        1'b0, NO_REPLY},
    '{OP_READ,     7'd64, 7'd1,  32'h0,        1'b0, NO_REPLY},
    '{OP_DEL_ROW,  7'd64, 7'd7,  32'h0,        1'b0, NO_REPLY},
    '{OP_DEL_COL,  7'd1,  7'd7,  32'h0,        1'b0, NO_REPLY},
    '{OP_INS_ROW,  7'd64, 7'd0,  32'h0,        1'b0, NO_REPLY},
    '{OP_INS_COL,  7'd1,  7'd0,  32'h0,        1'b0, NO_REPLY},
    '{OP_SWAP_ROW, 7'd0,  7'd3,  32'h0,        1'b1, '{32'sh0, ST_RANGE, 7'd64, 7'd64}},
    '{OP_DEL_ROW,  7'd0,  7'd0,  32'h0,        1'b1, '{32'sh0, ST_RANGE, 7'd64, 7'd64}}
  };

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [OP_W-1:0]              in_operation;
  logic [INDEX_W-1:0]           in_first_index;
  logic [INDEX_W-1:0]           in_second_index;
  logic signed [VALUE_W-1:0]    in_cell_value;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [VALUE_W-1:0]    out_read_value;
  logic [STATUS_W-1:0]          out_status;
  logic [INDEX_W-1:0]           out_rows_now;
  logic [INDEX_W-1:0]           out_cols_now;

  // Local copy of the table, its live size and the start-size registers
  logic [VALUE_W-1:0]  grid [ROWS_MAX][COLS_MAX];
  int                  live_rows = 0;
  int                  live_cols = 0;
  logic [INDEX_W-1:0]  start_rows = '0;
  logic [INDEX_W-1:0]  start_cols = '0;

  reply_t pending_replies [$];
  bit     quiet = 1'b0;
  int     fail_count = 0;
  int     edit_count = 0;
  int     reply_count = 0;
  int     range_count = 0;
  int     full_count = 0;

  matrix_row_column_editor #(
    .MAX_ROWS  (ROWS_MAX),
    .MAX_COLS  (COLS_MAX),
    .CELL_WIDTH(32)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_first_index (in_first_index),
    .in_second_index(in_second_index),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_rows_now   (out_rows_now),
    .out_cols_now   (out_cols_now)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one edit to the local table and return the reply it should give
  task automatic apply_edit(input logic [OP_W-1:0] op, input int a, input int b,
                            input logic [VALUE_W-1:0] value, output reply_t r);
    logic [VALUE_W-1:0] hold;
    int k;
    int m;
    r = NO_REPLY;
    r.status = ST_DONE;
    case (op)
      OP_LOAD, OP_READ: begin
        if (a < 1 || a > live_rows || b < 1 || b > live_cols) begin
          r.status = ST_RANGE;
        end else if (op == OP_LOAD) begin
          grid[a-1][b-1] = value;
        end else begin
          r.read_value = grid[a-1][b-1];
        end
      end
      OP_SWAP_ROW: begin
        if (a < 1 || a > live_rows || b < 1 || b > live_rows) begin
          r.status = ST_RANGE;
        end else begin
          for (k = 0; k < COLS_MAX; k++) begin
            hold = grid[a-1][k];
            grid[a-1][k] = grid[b-1][k];
            grid[b-1][k] = hold;
          end
        end
      end
      OP_SWAP_COL: begin
        if (a < 1 || a > live_cols || b < 1 || b > live_cols) begin
          r.status = ST_RANGE;
        end else begin
          for (k = 0; k < ROWS_MAX; k++) begin
            hold = grid[k][a-1];
            grid[k][a-1] = grid[k][b-1];
            grid[k][b-1] = hold;
          end
        end
      end
      OP_DEL_ROW: begin
        if (a < 1 || a > live_rows) begin
          r.status = ST_RANGE;
        end else begin
          // shift later rows up
          for (k = a; k < live_rows; k++)
            for (m = 0; m < COLS_MAX; m++) grid[k-1][m] = grid[k][m];
          live_rows--;
        end
      end
      OP_DEL_COL: begin
        if (a < 1 || a > live_cols) begin
          r.status = ST_RANGE;
        end else begin
          // shift later columns left
          for (k = a; k < live_cols; k++)
            for (m = 0; m < ROWS_MAX; m++) grid[m][k-1] = grid[m][k];
          live_cols--;
        end
      end
      OP_INS_ROW: begin
        if (a < 1 || a > live_rows + 1) begin
          r.status = ST_RANGE;
        end else if (live_rows >= ROWS_MAX) begin
          r.status = ST_FULL;
        end else begin
          // shift rows down from the insert point, then clear the new row
          for (k = live_rows; k >= a; k--)
            for (m = 0; m < COLS_MAX; m++) grid[k][m] = grid[k-1][m];
          for (m = 0; m < COLS_MAX; m++) grid[a-1][m] = '0;
          live_rows++;
        end
      end
      OP_INS_COL: begin
        if (a < 1 || a > live_cols + 1) begin
          r.status = ST_RANGE;
        end else if (live_cols >= COLS_MAX) begin
          r.status = ST_FULL;
        end else begin
          for (k = live_cols; k >= a; k--)
            for (m = 0; m < ROWS_MAX; m++) grid[m][k] = grid[m][k-1];
          for (m = 0; m < ROWS_MAX; m++) grid[m][a-1] = '0;
          live_cols++;
        end
      end
      OP_RESTART: begin
        // take the start sizes, saturated, and clear every cell
        live_rows = (start_rows > ROWS_MAX) ? ROWS_MAX : int'(start_rows);
        live_cols = (start_cols > COLS_MAX) ? COLS_MAX : int'(start_cols);
        for (k = 0; k < ROWS_MAX; k++)
          for (m = 0; m < COLS_MAX; m++) grid[k][m] = '0;
      end
      default: r.status = ST_RANGE;
    endcase
    r.rows_now = INDEX_W'(live_rows);
    r.cols_now = INDEX_W'(live_cols);
  endtask

  // Mostly a live line, sometimes any value from 0 to INDEX_LIMIT
  function automatic int pick_line(input int count);
    if (count >= 1 && $urandom_range(99) < 85)
      return $urandom_range((count > INDEX_LIMIT) ? INDEX_LIMIT : count, 1);
    return $urandom_range(INDEX_LIMIT, 0);
  endfunction

  function automatic edit_t random_edit();
    edit_t e;
    int pick;
    e = '0;
    e.value = $urandom;
    e.first = INDEX_W'($urandom_range(INDEX_LIMIT, 0));
    e.second = INDEX_W'($urandom_range(INDEX_LIMIT, 0));
    pick = $urandom_range(99);
    if (pick < 44) begin
      e.op = (pick < 22) ? OP_LOAD : OP_READ;
      e.first = INDEX_W'(pick_line(live_rows));
      e.second = INDEX_W'(pick_line(live_cols));
    end else if (pick < 52) begin
      e.op = OP_SWAP_ROW;
      e.first = INDEX_W'(pick_line(live_rows));
      e.second = INDEX_W'(pick_line(live_rows));
    end else if (pick < 60) begin
      e.op = OP_SWAP_COL;
      e.first = INDEX_W'(pick_line(live_cols));
      e.second = INDEX_W'(pick_line(live_cols));
    end else if (pick < 68) begin
      e.op = OP_DEL_ROW;
      e.first = INDEX_W'(pick_line(live_rows));
    end else if (pick < 76) begin
      e.op = OP_DEL_COL;
      e.first = INDEX_W'(pick_line(live_cols));
    end else if (pick < 84) begin
      e.op = OP_INS_ROW;
      e.first = INDEX_W'(pick_line(live_rows + 1));
    end else if (pick < 92) begin
      e.op = OP_INS_COL;
      e.first = INDEX_W'(pick_line(live_cols + 1));
    end else if (pick < 95) begin
      e.op = OP_RESTART;
    end else if (pick < 97) begin
      e.op = OP_W'($urandom_range(OP_UNUSED, OP_FIRST_UNUSED));
    end else begin
      e.op = OP_W'($urandom_range(OP_UNUSED, 0));
    end
    return e;
  endfunction

  // Write both start-size registers back to back
  task automatic load_start_size(input logic [CFG_DATA_W-1:0] rows,
                                 input logic [CFG_DATA_W-1:0] cols);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INIT_ROWS;
    cfg_data  <= rows;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    start_rows = rows;
    cfg_index <= CFG_INIT_COLS;
    cfg_data  <= cols;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    start_cols = cols;
    cfg_valid <= 1'b0;
  endtask

  // Present one edit beat, optionally after a random gap, and queue its expected reply
  task automatic send_edit(input edit_t e);
    reply_t predicted;
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 12) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= e.op;
    in_first_index  <= e.first;
    in_second_index <= e.second;
    in_cell_value   <= e.value;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_edit(e.op, int'(e.first), int'(e.second), e.value, predicted);
    pending_replies.push_back(e.typed ? e.want : predicted);
    edit_count++;
  endtask

  // Stall the result side at random, except in the quiet phase
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  // Check each accepted reply beat against the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no edit outstanding: status %0d rows %0d cols %0d",
               out_status, out_rows_now, out_cols_now);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        reply_count++;
        if (want.status == ST_RANGE) range_count++;
        if (want.status == ST_FULL) full_count++;
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_rows_now !== want.rows_now) begin
          $error("rows_now: expected %0d, got %0d", want.rows_now, out_rows_now);
          fail_count++;
        end
        if (out_cols_now !== want.cols_now) begin
          $error("cols_now: expected %0d, got %0d", want.cols_now, out_cols_now);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_INIT_ROWS;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_operation    = OP_LOAD;
    in_first_index  = '0;
    in_second_index = '0;
    in_cell_value   = '0;
    out_stall       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // scripted opening on an empty table, then a full one
    load_start_size(7'd64, 7'd64);
    foreach (SCRIPT[i]) send_edit(SCRIPT[i]);

    // random phases, each from its own start size
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clk);
      quiet = (p == QUIET_PHASE);
      load_start_size(PHASE_ROWS[p], PHASE_COLS[p]);
      send_edit(RESTART_EDIT);
      repeat (PHASE_EDITS) send_edit(random_edit());
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // drain, then watch a while for stray replies
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d edits over %0d start sizes; %0d replies checked", edit_count,
             PHASES + 1, reply_count);
    $display("Out-of-range rejects %0d, full-table rejects %0d, mismatches %0d",
             range_count, full_count, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
